### rtl/signed_radix_digit_formatter_defines.svh
// assertion macros for the signed radix digit formatter
// no dependencies; included by the top level
`ifndef SIGNED_RADIX_DIGIT_FORMATTER_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_FORMATTER_DEFINES_SVH

// condition must never hold outside reset
`define SRDF_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("srdf: forbidden condition");

// antecedent implies consequent in the same cycle
`define SRDF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srdf: implication failed");

`endif

### rtl/srdf_pkg.sv
// shared types, constants and symbol table helpers for the formatter
// no dependencies
package srdf_pkg;

  localparam int unsigned MaxRadixDefault = 16;
  localparam int unsigned MaxDigits       = 32;
  localparam int unsigned FifoDepth       = 2;
  localparam int unsigned ValueWidth      = 32;

  localparam logic [7:0] SymMinus = 8'd45;
  localparam logic [7:0] SymPlus  = 8'd43;
  localparam logic [7:0] SymSpace = 8'd32;
  localparam logic [7:0] SymDel   = 8'd127;

  typedef enum logic [1:0] {
    REG_RADIX  = 2'd0,
    REG_SYM_LO = 2'd1,
    REG_SYM_HI = 2'd2,
    REG_SPARE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [4:0]  radix;
    logic [63:0] sym_lo;
    logic [63:0] sym_hi;
  } cfg_t;

  typedef struct packed {
    logic                  neg;
    logic [ValueWidth-1:0] mag;
  } job_t;

  function automatic logic [7:0] symbol_at(input logic [3:0] d, input cfg_t cfg);
    logic [63:0] word;
    word = d[3] ? cfg.sym_hi : cfg.sym_lo;
    return word[{d[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic table_ok(input cfg_t cfg, input int unsigned max_radix);
    logic       ok;
    logic [7:0] s;
    ok = (cfg.radix >= 5'd2) && (32'(cfg.radix) <= max_radix) && (cfg.radix <= 5'd16);
    for (int i = 0; i < 16; i++) begin
      s = symbol_at(4'(i), cfg);
      if (5'(i) < cfg.radix) begin
        if (s <= SymSpace || s >= SymDel || s == SymPlus || s == SymMinus) ok = 1'b0;
        for (int j = i + 1; j < 16; j++) begin
          if (5'(j) < cfg.radix && symbol_at(4'(j), cfg) == s) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

### rtl/srdf_fifo.sv
// short job queue between front and back
// depends on srdf_pkg
module srdf_fifo
  import srdf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int unsigned AW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;

  job_t            mem_q [FifoDepth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]     cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == AW'(FifoDepth - 1)) ? '0 : wr_q + AW'(1);
    if (do_pop)  rd_d = (rd_q == AW'(FifoDepth - 1)) ? '0 : rd_q + AW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + (AW+1)'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - (AW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

### rtl/srdf_front.sv
// front end: takes values, checks the symbol table, forms sign and magnitude
// depends on srdf_pkg
module srdf_front
  import srdf_pkg::*;
#(
  parameter int unsigned MAX_RADIX = MaxRadixDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic signed [ValueWidth-1:0] value_i,
  input  cfg_t                         cfg_i,
  output logic                         job_push_o,
  output job_t                         job_o,
  input  logic                         job_full_i
);

  logic                  vld_q, vld_d;
  logic [ValueWidth-1:0] val_q;
  logic                  ok;
  logic                  leave;

  assign ok         = table_ok(cfg_i, MAX_RADIX);
  assign job_push_o = vld_q && ok && !job_full_i;
  // an item with a bad table leaves without a request
  assign leave      = vld_q && (!ok || !job_full_i);
  assign full_o     = vld_q && !leave;

  assign job_o.neg = val_q[ValueWidth-1];
  assign job_o.mag = val_q[ValueWidth-1] ? (~val_q + ValueWidth'(1)) : val_q;

  always_comb begin
    vld_d = vld_q;
    if (leave) vld_d = 1'b0;
    if (push_i && !full_o) vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) val_q <= value_i;
  end

endmodule

### rtl/srdf_back.sv
// back end: digit extraction by long division, digit stack, character output
// depends on srdf_pkg
module srdf_back
  import srdf_pkg::*;
#(
  parameter int unsigned MAX_RADIX = MaxRadixDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       job_empty_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] symbol_out_o,
  output logic       last_o
);

  localparam int unsigned DW = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int unsigned BitsPerStep = 8;
  localparam int unsigned Steps = ValueWidth / BitsPerStep;
  localparam int unsigned SW = $clog2(Steps);
  localparam int unsigned NW = $clog2(MaxDigits) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_DIGS = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [ValueWidth-1:0] div_q, div_d;
  logic [DW:0]           rem_q, rem_d;
  logic [SW-1:0]         step_q, step_d;
  logic [NW-1:0]         nd_q, nd_d;
  logic                  neg_q, neg_d;
  logic [DW-1:0]         stack_q [MaxDigits];
  logic                  stack_we;
  logic                  out_v_q, out_v_d;
  logic [7:0]            out_sym_q, out_sym_d;
  logic                  out_last_q, out_last_d;

  logic [DW:0]           rad;
  logic [DW:0]           r, t;
  logic                  qb;
  logic [ValueWidth-1:0] dn;
  logic                  free;
  logic [NW-2:0]         rd_idx;

  assign rad          = cfg_i.radix[DW:0];
  assign free         = !out_v_q || pop_i;
  assign rd_idx       = nd_q[NW-2:0] - (NW-1)'(1);
  assign job_pop_o    = (state_q == S_IDLE) && !job_empty_i;
  assign empty_o      = !out_v_q;
  assign symbol_out_o = out_sym_q;
  assign last_o       = out_last_q;

  // one chunk of restoring division by the radix
  always_comb begin
    r  = rem_q;
    dn = div_q;
    for (int i = 0; i < BitsPerStep; i++) begin
      t  = {r[DW-1:0], dn[ValueWidth-1]};
      qb = (t >= rad);
      r  = qb ? (t - rad) : t;
      dn = {dn[ValueWidth-2:0], qb};
    end
  end

  always_comb begin
    state_d    = state_q;
    div_d      = div_q;
    rem_d      = rem_q;
    step_d     = step_q;
    nd_d       = nd_q;
    neg_d      = neg_q;
    stack_we   = 1'b0;
    out_v_d    = out_v_q && !pop_i;
    out_sym_d  = out_sym_q;
    out_last_d = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          div_d   = job_i.mag;
          neg_d   = job_i.neg;
          rem_d   = '0;
          step_d  = '0;
          nd_d    = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        div_d  = dn;
        rem_d  = r;
        step_d = step_q + SW'(1);
        if (step_q == SW'(Steps - 1)) begin
          stack_we = 1'b1;
          nd_d     = nd_q + NW'(1);
          rem_d    = '0;
          step_d   = '0;
          if (dn == '0 || nd_q == NW'(MaxDigits - 1)) begin
            state_d = neg_q ? S_SIGN : S_DIGS;
          end
        end
      end
      S_SIGN: begin
        if (free) begin
          out_v_d    = 1'b1;
          out_sym_d  = SymMinus;
          out_last_d = 1'b0;
          state_d    = S_DIGS;
        end
      end
      S_DIGS: begin
        if (free) begin
          out_v_d    = 1'b1;
          out_sym_d  = symbol_at(4'(stack_q[rd_idx]), cfg_i);
          out_last_d = (nd_q == NW'(1));
          nd_d       = nd_q - NW'(1);
          if (nd_q == NW'(1)) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      nd_q    <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      nd_q    <= nd_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q      <= div_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
    if (stack_we) stack_q[nd_q[NW-2:0]] <= r[DW-1:0];
  end

endmodule

### rtl/signed_radix_digit_formatter.sv
// top level of the signed radix digit formatter: config registers and wiring
// depends on srdf_pkg, srdf_front, srdf_fifo, srdf_back and the defines header
//
// usage
//   input: drive value_i and raise push; a value is taken on a clock edge with
//   push high and full low. output: while empty is low, symbol_out_o/last_o
//   hold the oldest character; raise pop to take it. last_o marks the final
//   character of a number, a negative number starts with '-'.
//   config: cfg_we_i with cfg_idx_i 0 = radix, 1 = symbols 0..7, 2 = symbols
//   8..15; write only while the block is idle. a bad symbol table drops items.
//   flow: the front stage registers each value, which then enters the job queue;
//   the shared 8-bit-per-cycle divider works out each digit, then one character
//   leaves per cycle while the receiver pops. the back takes the next job only
//   once the last character of the previous one is in the output register.
//   the front takes new values while the back works, up to the queue depth.
//   a stalled receiver holds the output register; the back waits and the
//   queue and front fill up behind it.
//   reset clears all control state and config registers to zero.
`include "signed_radix_digit_formatter_defines.svh"

module signed_radix_digit_formatter
  import srdf_pkg::*;
#(
  parameter int unsigned MAX_RADIX = MaxRadixDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [ValueWidth-1:0] value_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   symbol_out_o,
  output logic                         last_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [63:0]                  cfg_wdata_i
);

  cfg_t cfg_q;
  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIX:  cfg_q.radix  <= cfg_wdata_i[4:0];
        REG_SYM_LO: cfg_q.sym_lo <= cfg_wdata_i;
        REG_SYM_HI: cfg_q.sym_hi <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  srdf_front #(.MAX_RADIX(MAX_RADIX)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .value_i    (value_i),
    .cfg_i      (cfg_q),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  srdf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  srdf_back #(.MAX_RADIX(MAX_RADIX)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .job_empty_i  (job_empty),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .symbol_out_o (symbol_out_o),
    .last_o       (last_o)
  );

  `SRDF_ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, job_push && job_full)
  `SRDF_ASSERT_NEVER(a_queue_underflow, clk_i, rst_ni, job_pop && job_empty)
  `SRDF_ASSERT_IMPL(a_minus_not_last, clk_i, rst_ni, !empty && symbol_out_o == SymMinus, !last_o)
  `SRDF_ASSERT_IMPL(a_out_needs_table, clk_i, rst_ni, !empty, cfg_q.radix >= 5'd2)

endmodule

### test/tb_signed_radix_digit_formatter.sv
// testbench for signed_radix_digit_formatter: directed and random values, several tables
// depends on srdf_pkg and the formatter rtl; a scoreboard class predicts each character
`timescale 1ns / 1ps

module tb_signed_radix_digit_formatter
  import srdf_pkg::*;
;

  localparam int MaxRadix    = int'(MaxRadixDefault);
  localparam int DrainCycles = 800;
  localparam int CycleLimit  = 1_000_000;
  localparam int ItemTarget  = 480;

  typedef enum int {
    BAD_RADIX,
    BAD_SYMBOL,
    DUP_SYMBOL
  } table_fault_e;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } char_t;

  class char_scoreboard;
    char_t       pending_chars[$];
    int unsigned mismatches;
    logic [4:0]  radix;
    logic [63:0] sym_lo;
    logic [63:0] sym_hi;

    function new();
      mismatches = 0;
      radix      = '0;
      sym_lo     = '0;
      sym_hi     = '0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [63:0] data);
      case (idx)
        REG_RADIX:  radix = data[4:0];
        REG_SYM_LO: sym_lo = data;
        REG_SYM_HI: sym_hi = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] digit_symbol(logic [3:0] d);
      logic [63:0] w;
      w = d[3] ? sym_hi : sym_lo;
      return w[8*d[2:0] +: 8];
    endfunction

    function bit table_valid();
      logic [7:0] s;
      if (radix < 2 || radix > MaxRadix) return 1'b0;
      for (int i = 0; i < radix; i++) begin
        s = digit_symbol(4'(i));
        if (s <= SymSpace || s >= SymDel || s == SymPlus || s == SymMinus) return 1'b0;
        for (int j = i + 1; j < radix; j++) begin
          if (digit_symbol(4'(j)) == s) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // expected characters for one accepted value request
    function void note_value(logic signed [31:0] v);
      logic [32:0] mag;
      logic [7:0]  digs [32];
      int          nd;
      char_t       c;
      if (!table_valid()) return;
      mag = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
      nd  = 0;
      do begin
        digs[nd] = digit_symbol(4'(mag % radix));
        nd++;
        mag = mag / radix;
      end while (mag != 0 && nd < 32);
      if (v[31]) begin
        c.sym  = SymMinus;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        c.sym  = digs[k];
        c.last = (k == 0);
        pending_chars.push_back(c);
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    task check_char(logic [7:0] sym, logic last);
      char_t c;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected char %h last %b", sym, last));
      end else begin
        c = pending_chars.pop_front();
        if (c.sym !== sym) report($sformatf("symbol %h, expected %h", sym, c.sym));
        if (c.last !== last) report($sformatf("last %b, expected %b", last, c.last));
      end
    endtask

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  push      = 1'b0;
  logic                  full;
  logic signed [31:0]    value_i   = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  logic [7:0]            symbol_out_o;
  logic                  last_o;
  logic                  cfg_we_i  = 1'b0;
  logic [1:0]            cfg_idx_i = REG_RADIX;
  logic [63:0]           cfg_wdata_i = '0;

  char_scoreboard sb;
  int             tx_idle_pct = 8;
  int             rx_idle_pct = 59;
  int unsigned    cycles = 0;

  signed_radix_digit_formatter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .empty        (empty),
    .pop          (pop),
    .symbol_out_o (symbol_out_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_char(symbol_out_o, last_o);
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_value(input logic signed [31:0] v);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk_i);
    end
    push    <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_value(v);
  endtask

  // all characters out, then room for requests the table drops
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_table(input logic [63:0] radix_word, input logic [63:0] lo,
                           input logic [63:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_RADIX;
    cfg_wdata_i <= radix_word;
    sb.set_reg(REG_RADIX, radix_word);
    @(posedge clk_i);
    cfg_idx_i   <= REG_SYM_LO;
    cfg_wdata_i <= lo;
    sb.set_reg(REG_SYM_LO, lo);
    @(posedge clk_i);
    cfg_idx_i   <= REG_SYM_HI;
    cfg_wdata_i <= hi;
    sb.set_reg(REG_SYM_HI, hi);
    @(posedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      cfg_idx_i   <= REG_SPARE;
      cfg_wdata_i <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] printable_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 126)); while (b == SymPlus || b == SymMinus);
    return b;
  endfunction

  function automatic logic [7:0] bad_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 32));
      1: return 8'($urandom_range(127, 255));
      2: return SymPlus;
      default: return SymMinus;
    endcase
  endfunction

  task automatic make_table(input bit want_valid, output logic [63:0] radix_word,
                            output logic [63:0] lo, output logic [63:0] hi);
    logic [7:0]   syms [16];
    bit           used [256];
    int unsigned  r;
    int unsigned  pick;
    int unsigned  i_bad;
    int unsigned  j_src;
    table_fault_e fault;
    logic [7:0]   b;
    pick = $urandom_range(0, 3);
    r = (pick == 0) ? 2 : (pick == 1) ? MaxRadix : $urandom_range(2, MaxRadix);
    foreach (used[k]) used[k] = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (i < r || $urandom_range(0, 1)) begin
        do b = printable_byte(); while (used[b]);
        used[b] = 1'b1;
        syms[i] = b;
      end else begin
        syms[i] = 8'($urandom);
      end
    end
    if (!want_valid) begin
      fault = table_fault_e'($urandom_range(0, 2));
      i_bad = $urandom_range(0, r - 1);
      case (fault)
        BAD_RADIX: begin
          r = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1)
                                          : $urandom_range(MaxRadix + 1, 31);
        end
        BAD_SYMBOL: syms[i_bad] = bad_byte();
        default: begin
          do j_src = $urandom_range(0, r - 1); while (j_src == i_bad);
          syms[i_bad] = syms[j_src];
        end
      endcase
    end
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = syms[i];
      hi[8*i +: 8] = syms[i+8];
    end
    radix_word = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
    radix_word[4:0] = 5'(r);
  endtask

  function automatic logic signed [31:0] random_value();
    logic [31:0] v;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      v = $urandom;
    end else if (sel < 65) begin
      v = $urandom >> $urandom_range(1, 31);
      if ($urandom_range(0, 1)) v = -v;
    end else if (sel < 85) begin
      v = $urandom_range(0, 40);
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      case ($urandom_range(0, 4))
        0: v = 32'h0000_0000;
        1: v = 32'h0000_0001;
        2: v = 32'hFFFF_FFFF;
        3: v = 32'h7FFF_FFFF;
        default: v = 32'h8000_0000;
      endcase
    end
    return v;
  endfunction

  localparam logic [63:0] DecLo = 64'h3736_3534_3332_3130;
  localparam logic [63:0] DecHi = 64'h00FF_2D2B_2000_3938;

  initial begin
    logic [63:0] rw;
    logic [63:0] lo;
    logic [63:0] hi;
    bit          want_valid;
    int unsigned n;
    int unsigned counted;
    sb = new();
    counted = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset table is empty, requests give nothing
    send_value(32'sd0);
    send_value(-32'sd1);
    settle();

    // decimal, unused bytes hold junk
    set_table(64'd10, DecLo, DecHi);
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'sd1000000000);
    send_value(-32'sd987654321);
    settle();

    set_table(64'd2, 64'h2D2D_2D2D_2D2D_3130, 64'd0);
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sd0);
    settle();

    // symbols at the printable edges
    set_table(64'd16, 64'h4746_4544_4342_4121, 64'h7E4E_4D4C_4B4A_4948);
    send_value(32'sd0);
    send_value(32'sh8000_0000);
    send_value(-32'sd1);
    settle();

    // broken tables
    set_table(64'd1, DecLo, DecHi);
    send_value(-32'sd5);
    settle();
    set_table(64'd17, DecLo, 64'h4746_4544_4342_3938);
    send_value(-32'sd5);
    settle();
    set_table(64'd31, DecLo, 64'h4746_4544_4342_3938);
    send_value(-32'sd5);
    settle();
    set_table(64'd10, DecLo, 64'h0000_0000_0000_3038);
    send_value(-32'sd5);
    settle();
    set_table(64'd10, 64'h3736_3534_2B32_3130, DecHi);
    send_value(-32'sd5);
    settle();
    set_table(64'd10, 64'h3736_3534_3332_312D, DecHi);
    send_value(-32'sd5);
    settle();
    set_table(64'd10, 64'h3736_2034_3332_3130, DecHi);
    send_value(-32'sd5);
    settle();
    set_table(64'd10, DecLo, 64'h0000_0000_0000_7F38);
    send_value(-32'sd5);
    settle();
    set_table(64'd10, 64'h3736_3534_3380_3130, DecHi);
    send_value(-32'sd5);
    settle();

    while (counted < ItemTarget) begin
      if (counted < ItemTarget / 3) begin
        tx_idle_pct = 8;
        rx_idle_pct = 59;
      end else if (counted < 2 * ItemTarget / 3) begin
        tx_idle_pct = 59;
        rx_idle_pct = 8;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      want_valid = ($urandom_range(0, 99) < 80);
      make_table(want_valid, rw, lo, hi);
      set_table(rw, lo, hi);
      n = want_valid ? $urandom_range(20, 50) : $urandom_range(2, 6);
      repeat (n) send_value(random_value());
      if (sb.table_valid()) counted += n;
      settle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/srdf_pkg.sv
rtl/srdf_fifo.sv
rtl/srdf_front.sv
rtl/srdf_back.sv
rtl/signed_radix_digit_formatter.sv
test/tb_signed_radix_digit_formatter.sv
